// File: rtl/core/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared constants, types and codes for the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  localparam int CPU_COUNT   = 8;
  localparam int CPU_W       = 3;
  localparam int PART_PAGES  = 256;
  localparam int PART_W      = 8;
  localparam int PAGE_SHIFT  = 12;
  localparam int TOTAL_PAGES = CPU_COUNT * PART_PAGES;
  localparam int PAGE_W      = 11;
  localparam int LINK_W      = 12;
  localparam int NIL_PAGE    = TOTAL_PAGES;
  localparam int ADDR_W      = 56;
  localparam int STAT_W      = 2;

  localparam int IN_DW  = 64;
  localparam int OUT_DW = 64;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 64;

  localparam logic [ADDR_W-1:0] BASE_RESET = 56'd0;
  localparam logic [ADDR_W-1:0] TOP_RESET  = 56'd134217728;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic {
    REG_BASE = 1'b0,
    REG_TOP  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_PAGE  = 2'd1,
    STAT_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic exec_free;
    logic alloc_read;
    logic alloc_miss;
    logic alloc_done;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic alloc_hit;
    logic slot_free;
  } sts_t;

endpackage

// File: rtl/core/pcpa_ram.sv
// ----------------------------------------------------------------------------
// pcpa_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module pcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/pcpa_cfg.sv
// ----------------------------------------------------------------------------
// pcpa_cfg
// APB register file: region base and region top.
// ----------------------------------------------------------------------------
module pcpa_cfg import pcpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output addr_t             region_base,
  output addr_t             region_top
);

  addr_t    base_r, base_nxt;
  addr_t    top_r, top_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[3]);

  always_comb begin
    base_nxt = base_r;
    top_nxt  = top_r;
    if (wr_en) begin
      unique case (idx)
        REG_BASE: base_nxt = cfg_pwdata[ADDR_W-1:0];
        REG_TOP:  top_nxt  = cfg_pwdata[ADDR_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      top_r  <= TOP_RESET;
    end else begin
      base_r <= base_nxt;
      top_r  <= top_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE: cfg_prdata = CFG_DW'(base_r);
      REG_TOP:  cfg_prdata = CFG_DW'(top_r);
      default:  cfg_prdata = '0;
    endcase
  end

  assign region_base = base_r;
  assign region_top  = top_r;

endmodule

// File: rtl/core/pcpa_ctrl.sv
// ----------------------------------------------------------------------------
// pcpa_ctrl
// Sequencer: link table init, transaction intake, free / allocate steps.
// ----------------------------------------------------------------------------
module pcpa_ctrl import pcpa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.is_free) begin
          if (sts.slot_free) state_nxt = ST_IDLE;
        end else if (sts.alloc_hit) begin
          state_nxt = ST_READ;
        end else if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec_free  = sts.is_free & sts.slot_free;
        cmd.alloc_read = ~sts.is_free & sts.alloc_hit;
        cmd.alloc_miss = ~sts.is_free & ~sts.alloc_hit & sts.slot_free;
      end
      ST_READ: cmd.alloc_done = sts.slot_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/pcpa_dp.sv
// ----------------------------------------------------------------------------
// pcpa_dp
// Datapath: list heads, next-link RAM, free checks, grant address, output reg.
// ----------------------------------------------------------------------------
module pcpa_dp import pcpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic              in_tuser,
  input  addr_t             region_base,
  input  addr_t             region_top,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [OUT_DW-1:0] out_tdata
);

  action_t          act_r, act_nxt;
  logic [CPU_W-1:0] cpu_r, cpu_nxt;
  addr_t            addr_r, addr_nxt;
  link_t            head_r [CPU_COUNT];
  link_t            head_nxt [CPU_COUNT];
  link_t            clr_cnt_r, clr_cnt_nxt;
  logic [CPU_W-1:0] sel_r, sel_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic             out_valid_r, out_valid_nxt;
  addr_t            out_addr_r, out_addr_nxt;
  status_t          out_stat_r, out_stat_nxt;

  addr_t             eff_base;
  addr_t             diff;
  logic              bad;
  logic [PAGE_W-1:0] fpage;
  logic [CPU_W-1:0]  fpart;
  logic              hit;
  logic [CPU_W-1:0]  sel;
  logic              clr_done;
  logic              slot_free;
  logic              out_load;
  addr_t             grant;

  logic              ram_we;
  logic [PAGE_W-1:0] ram_waddr;
  link_t             ram_wdata;
  link_t             ram_rdata;

  pcpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TOTAL_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.alloc_read),
    .raddr (head_r[sel][PAGE_W-1:0]),
    .rdata (ram_rdata)
  );

  // free checks
  assign eff_base = {region_base[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
  assign diff     = addr_r - eff_base;
  assign bad      = (|addr_r[PAGE_SHIFT-1:0]) || (addr_r < eff_base) ||
                    (addr_r >= region_top) ||
                    (|diff[ADDR_W-1:PAGE_SHIFT+PAGE_W]);
  assign fpage    = diff[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT];
  assign fpart    = fpage[PAGE_W-1:PART_W];

  // own list first, then first non-empty list
  always_comb begin
    hit = 1'b0;
    sel = cpu_r;
    if (head_r[cpu_r] < LINK_W'(NIL_PAGE)) begin
      hit = 1'b1;
    end else begin
      for (int i = 0; i < CPU_COUNT; i++) begin
        if (!hit && (head_r[i] < LINK_W'(NIL_PAGE))) begin
          hit = 1'b1;
          sel = CPU_W'(i);
        end
      end
    end
  end

  assign clr_done  = (clr_cnt_r == LINK_W'(TOTAL_PAGES));
  assign slot_free = ~out_valid_r | out_tready;
  assign grant     = eff_base + ADDR_W'({page_r, PAGE_SHIFT'(0)});

  // link RAM write: init sweep or free push
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fpage;
    ram_wdata = head_r[fpart];
    if (cmd.clr_step) begin
      ram_we    = ~clr_done;
      ram_waddr = clr_cnt_r[PAGE_W-1:0];
      ram_wdata = (clr_cnt_r[PART_W-1:0] == '0) ? LINK_W'(NIL_PAGE) : clr_cnt_r - 1'b1;
    end else if (cmd.exec_free) begin
      ram_we = ~bad;
    end
  end

  always_comb begin
    act_nxt     = act_r;
    cpu_nxt     = cpu_r;
    addr_nxt    = addr_r;
    clr_cnt_nxt = clr_cnt_r;
    sel_nxt     = sel_r;
    page_nxt    = page_r;
    for (int i = 0; i < CPU_COUNT; i++) begin
      head_nxt[i] = head_r[i];
    end
    if (cmd.clr_step && !clr_done) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
    if (cmd.load_in) begin
      act_nxt  = action_t'(in_tuser);
      cpu_nxt  = in_tdata[CPU_W-1:0];
      addr_nxt = in_tdata[CPU_W+ADDR_W-1:CPU_W];
    end
    if (cmd.exec_free && !bad) begin
      head_nxt[fpart] = {1'b0, fpage};
    end
    if (cmd.alloc_read) begin
      sel_nxt  = sel;
      page_nxt = head_r[sel][PAGE_W-1:0];
    end
    if (cmd.alloc_done) begin
      head_nxt[sel_r] = ram_rdata;
    end
  end

  assign out_load = cmd.exec_free | cmd.alloc_miss | cmd.alloc_done;

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_tready;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_addr_nxt  = cmd.alloc_done ? grant : '0;
      priority if (cmd.exec_free) begin
        out_stat_nxt = bad ? STAT_BAD_FREE : STAT_OK;
      end else if (cmd.alloc_miss) begin
        out_stat_nxt = STAT_NO_PAGE;
      end else begin
        out_stat_nxt = STAT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CPU_COUNT; i++) begin
        head_r[i] <= LINK_W'(i * PART_PAGES + PART_PAGES - 1);
      end
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < CPU_COUNT; i++) begin
        head_r[i] <= head_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    cpu_r      <= cpu_nxt;
    addr_r     <= addr_nxt;
    sel_r      <= sel_nxt;
    page_r     <= page_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign sts.clr_done  = clr_done;
  assign sts.is_free   = (act_r == ACT_FREE);
  assign sts.alloc_hit = hit;
  assign sts.slot_free = slot_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW-ADDR_W-STAT_W)'(0), out_stat_r, out_addr_r};

endmodule

// File: rtl/core/per_cpu_page_free_list_allocator_unit.sv
// Results: a free or an exhausted allocate loads the output register from the
// execute state, a granted allocate from the read state that follows it
// (registered next-link RAM read). One transaction is handled at a time;
// in_tready is high only in the idle state, and a held result stalls the input.
// Reset: synchronous, active low; a sweep then initializes every entry of the
// link RAM, with in_tready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator_unit
// Per-CPU LIFO page free lists with stealing, stream request/response.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator_unit import pcpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // requester_cpu[2:0], page_address[58:3]
  input  logic              in_tuser,   // action[0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // granted_address[55:0], status[57:56]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  addr_t region_base;
  addr_t region_top;
  cmd_t  cmd;
  sts_t  sts;

  pcpa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .region_base (region_base),
    .region_top  (region_top)
  );

  pcpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcpa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .region_base (region_base),
    .region_top  (region_top),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

endmodule
